@@ rtl/fqs_pkg.sv @@
// fqs_pkg: shared constants, types and helpers of the FIFO queue with search.
// No dependencies; imported by every module of the block.
package fqs_pkg;

    // Queue depth and the widths that follow from it
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the command and result beats
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int ECNT_W = 5;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_SRCH = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SRCH
    } state_t;

    // Access to the entry store: one write and one read port
    typedef struct packed {
        logic  we;
        idx_t  waddr;
        data_t wdata;
        logic  re;
        idx_t  raddr;
    } mem_req_t;

    // Ring index advance with wrap at DEPTH-1
    function automatic idx_t ring_next(input idx_t idx);
        idx_t res;
        if (idx == idx_t'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + idx_t'(1);
        end
        return res;
    endfunction

endpackage

@@ rtl/fqs_store.sv @@
// fqs_store: entry store of the queue, a synchronous RAM with one write port
// and one read port, read data registered. Depends on fqs_pkg.
module fqs_store (
    input  logic             clk,
    input  fqs_pkg::mem_req_t req,
    output fqs_pkg::data_t   rd_data
);
    import fqs_pkg::*;

    data_t mem [DEPTH];
    data_t rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/fifo_queue_with_search_top.sv @@
// FIFO queue of signed 32-bit values with linear search over a ring store.
// Holds the controller; depends on fqs_pkg and fqs_store.
//
// A command beat is taken when start is high and busy is low; every command
// gives exactly one result beat, shown for one cycle with done high, and the
// receiver cannot stall it. Enqueue and the unused code give their result in
// the cycle after the command, as do dequeue and search on an empty queue;
// otherwise dequeue reads the head entry from the registered-read store and
// gives its result from state S_DEQ, and search reads one entry a cycle from
// the head in state S_SRCH until an entry matches or the last entry held has
// been compared. A new command may be given in the cycle in which the
// previous result is shown.
module fifo_queue_with_search_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    func,
    input  logic signed [31:0]            data_value,
    input  logic signed [31:0]            search_key,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [fqs_pkg::POS_W-1:0]     position,
    output logic signed [31:0]            removed_value,
    output logic [fqs_pkg::ECNT_W-1:0]    entry_count
);
    import fqs_pkg::*;

    state_t   state_reg, state_next;
    idx_t     head_reg, head_next;
    idx_t     tail_reg, tail_next;
    cnt_t     count_reg, count_next;
    idx_t     scan_idx_reg, scan_idx_next;
    idx_t     scan_pos_reg, scan_pos_next;
    data_t    key_reg, key_next;
    logic     done_reg, done_next;
    status_t  status_reg, status_next;
    logic [POS_W-1:0]  position_reg, position_next;
    data_t    removed_reg, removed_next;
    logic [ECNT_W-1:0] ecount_reg, ecount_next;

    mem_req_t mem_req;
    data_t    rd_data;
    logic     accept;
    logic     hit;
    logic     last;

    fqs_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign accept = start && (state_reg == S_IDLE);
    assign hit    = (rd_data == key_reg);
    assign last   = ((cnt_t'(scan_pos_reg) + cnt_t'(1)) == count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(func))
                        OP_DEQ:  state_next = (count_reg == '0) ? S_IDLE : S_DEQ;
                        OP_SRCH: state_next = (count_reg == '0) ? S_IDLE : S_SRCH;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_DEQ:
            begin
                state_next = S_IDLE;
            end
            S_SRCH:
            begin
                if (hit || last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, store access and result beat
    always_comb
    begin
        mem_req       = '0;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        scan_pos_next = scan_pos_reg;
        key_next      = key_reg;
        done_next     = 1'b0;
        status_next   = STAT_OK;
        position_next = '0;
        removed_next  = '0;
        ecount_next   = ecount_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(func))
                        OP_ENQ:
                        begin
                            done_next = 1'b1;
                            if (count_reg == cnt_t'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = tail_reg;
                                mem_req.wdata = data_value;
                                tail_next     = ring_next(tail_reg);
                                count_next    = count_reg + cnt_t'(1);
                            end
                            ecount_next = ECNT_W'(count_next);
                        end
                        OP_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_EMPTY;
                                ecount_next = ECNT_W'(count_reg);
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = head_reg;
                            end
                        end
                        OP_SRCH:
                        begin
                            key_next = search_key;
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_NOT_FOUND;
                                ecount_next = ECNT_W'(count_reg);
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = head_reg;
                                scan_idx_next = ring_next(head_reg);
                                scan_pos_next = '0;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            ecount_next = ECNT_W'(count_reg);
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                // Head entry arrives from the store this cycle
                done_next    = 1'b1;
                removed_next = rd_data;
                head_next    = ring_next(head_reg);
                count_next   = count_reg - cnt_t'(1);
                ecount_next  = ECNT_W'(count_next);
            end
            S_SRCH:
            begin
                // rd_data holds the entry at scan_pos_reg from the head
                if (hit)
                begin
                    done_next     = 1'b1;
                    position_next = POS_W'(scan_pos_reg);
                    ecount_next   = ECNT_W'(count_reg);
                end
                else if (last)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_NOT_FOUND;
                    ecount_next = ECNT_W'(count_reg);
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = scan_idx_reg;
                    scan_idx_next = ring_next(scan_idx_reg);
                    scan_pos_next = scan_pos_reg + idx_t'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Scan pointers and result payload
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        scan_pos_reg <= scan_pos_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        position_reg <= position_next;
        removed_reg  <= removed_next;
        ecount_reg   <= ecount_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign position      = position_reg;
    assign removed_value = removed_reg;
    assign entry_count   = ecount_reg;

endmodule

@@ rtl/fqs_check.sv @@
// fqs_check: port-level assertions on the FIFO queue with search, bound to
// fifo_queue_with_search_top. Depends on fqs_pkg.
module fqs_check (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [1:0]                 func,
    input  logic                       done,
    input  logic [1:0]                 status,
    input  logic [fqs_pkg::ECNT_W-1:0] entry_count
);
    import fqs_pkg::*;

    // A result beat only appears once the operation has finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat shown while busy");

    // Enqueue and the unused code complete in the cycle after the command
    a_enq_one: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == OP_ENQ || func == OP_NOP)) |=> (done && !busy))
        else $error("single-cycle command did not complete");

    // Dequeue either finishes at once (empty) or is still working
    a_deq_prog: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == OP_DEQ) |=> (done || busy))
        else $error("dequeue lost");

    // Empty report only with no entries held
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_EMPTY) |-> (entry_count == '0))
        else $error("empty status with entries held");

    // Full report only with DEPTH entries held
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_FULL) |-> (entry_count == ECNT_W'(DEPTH)))
        else $error("full status with free entries");

endmodule

bind fifo_queue_with_search_top fqs_check u_fqs_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .done        (done),
    .status      (status),
    .entry_count (entry_count)
);
